/* design/stm_pkg.sv */
package stm_pkg;

	// tail window: five held cells plus the incoming character
	localparam int WIN_CELLS = 5;
	localparam int OUT_CELLS = 6;
	localparam int NUM_RULES = 22;

	localparam logic [7:0] CHAR_Y = 8'h79;

	// one output beat
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [2:0] rem;
		logic       ovf;
	} beat_t;

	// window cell control
	typedef struct packed {
		logic shift;
		logic clear;
	} wctl_t;

	// output cell control
	typedef struct packed {
		logic pop;
		logic push;
		logic load;
	} octl_t;

	// suffix rule: byte k of sfx is the k-th character counted from the end
	typedef struct packed {
		logic [39:0] sfx;
		logic [2:0]  len;
		logic        add_y;
		logic        undbl;
	} rule_t;

	// taken in order, the first match wins
	localparam rule_t RULES [NUM_RULES] = '{
		'{40'("ation"), 3'd5, 1'b0, 1'b0},
		'{40'("ition"), 3'd5, 1'b0, 1'b0},
		'{40'("ness"),  3'd4, 1'b0, 1'b0},
		'{40'("ment"),  3'd4, 1'b0, 1'b0},
		'{40'("able"),  3'd4, 1'b0, 1'b0},
		'{40'("ible"),  3'd4, 1'b0, 1'b0},
		'{40'("tion"),  3'd4, 1'b0, 1'b0},
		'{40'("sion"),  3'd4, 1'b0, 1'b0},
		'{40'("ies"),   3'd3, 1'b1, 1'b0},
		'{40'("ied"),   3'd3, 1'b1, 1'b0},
		'{40'("ing"),   3'd3, 1'b0, 1'b1},
		'{40'("est"),   3'd3, 1'b0, 1'b0},
		'{40'("ous"),   3'd3, 1'b0, 1'b0},
		'{40'("ive"),   3'd3, 1'b0, 1'b0},
		'{40'("ful"),   3'd3, 1'b0, 1'b0},
		'{40'("ize"),   3'd3, 1'b0, 1'b0},
		'{40'("ise"),   3'd3, 1'b0, 1'b0},
		'{40'("ed"),    3'd2, 1'b0, 1'b1},
		'{40'("er"),    3'd2, 1'b0, 1'b0},
		'{40'("ly"),    3'd2, 1'b0, 1'b0},
		'{40'("es"),    3'd2, 1'b0, 1'b0},
		'{40'("s"),     3'd1, 1'b0, 1'b0}
	};

endpackage

/* design/stm_win_cell.sv */
module stm_win_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  stm_pkg::wctl_t ctl,
	input  logic [7:0]    nxt_ch,
	input  logic          nxt_vld,
	output logic [7:0]    ch,
	output logic          vld
);
	import stm_pkg::*;

	logic [7:0] ch_q;
	logic       vld_q;

	// occupancy: cleared at word end, taken from the neighbor on shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= nxt_vld;
		end
	end

	// character byte
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ch_q <= nxt_ch;
		end
	end

	assign ch  = ch_q;
	assign vld = vld_q;

endmodule

/* design/stm_out_cell.sv */
module stm_out_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  stm_pkg::octl_t ctl,
	input  stm_pkg::beat_t nxt_beat,
	input  logic           nxt_vld,
	input  logic           prv_sv,
	input  stm_pkg::beat_t push_beat,
	input  stm_pkg::beat_t ld_beat,
	input  logic           ld_vld,
	output stm_pkg::beat_t beat,
	output logic           vld,
	output logic           sv
);
	import stm_pkg::*;

	beat_t beat_q;
	logic  vld_q;
	logic  take_push;

	// occupancy after the head beat leaves
	assign sv = ctl.pop ? nxt_vld : vld_q;

	// a single beat lands in the first free cell
	assign take_push = ctl.push && !sv && prv_sv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			priority if (ctl.load) begin
				vld_q <= ld_vld;
			end else if (take_push) begin
				vld_q <= 1'b1;
			end else begin
				vld_q <= sv;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			beat_q <= ld_beat;
		end else if (take_push) begin
			beat_q <= push_beat;
		end else if (ctl.pop) begin
			beat_q <= nxt_beat;
		end
	end

	assign beat = beat_q;
	assign vld  = vld_q;

endmodule

/* design/stm_match.sv */
module stm_match (
	input  logic [stm_pkg::OUT_CELLS-1:0][7:0] win,
	input  logic [stm_pkg::OUT_CELLS-1:0]      win_vld,
	input  logic [3:0]                         len_cap,
	input  logic                               ovf,
	output stm_pkg::beat_t [stm_pkg::OUT_CELLS-1:0] beats,
	output logic [stm_pkg::OUT_CELLS-1:0]      beat_vld
);
	import stm_pkg::*;

	function automatic logic doublable(input logic [7:0] c);
		return c == 8'("n") || c == 8'("p") || c == 8'("t") || c == 8'("d") ||
		       c == 8'("g") || c == 8'("m") || c == 8'("b") || c == 8'("l") ||
		       c == 8'("r");
	endfunction

	logic [NUM_RULES-1:0] hit;
	logic       found;
	logic [2:0] sel_len;
	logic       sel_y;
	logic       sel_ud;
	logic [2:0] held;
	logic [2:0] keep_pre;
	logic       dbl;
	logic       undo;
	logic [2:0] keep;
	logic [2:0] removed;
	logic [2:0] nb;
	logic [2:0] offset;
	logic [2:0] src;

	// all rules compared in parallel against the right-aligned tail
	always_comb begin
		for (int r = 0; r < NUM_RULES; r++) begin
			hit[r] = !ovf && (len_cap >= 4'(RULES[r].len) + 4'd3) &&
			         win_vld[OUT_CELLS - int'(RULES[r].len)];
			for (int k = 0; k < WIN_CELLS; k++) begin
				if (k < int'(RULES[r].len) &&
				    win[OUT_CELLS-1-k] != RULES[r].sfx[8*k +: 8]) begin
					hit[r] = 1'b0;
				end
			end
		end
	end

	// first matching rule wins
	always_comb begin
		found   = 1'b0;
		sel_len = 3'd0;
		sel_y   = 1'b0;
		sel_ud  = 1'b0;
		for (int r = 0; r < NUM_RULES; r++) begin
			if (!found && hit[r]) begin
				found   = 1'b1;
				sel_len = RULES[r].len;
				sel_y   = RULES[r].add_y;
				sel_ud  = RULES[r].undbl;
			end
		end
	end

	// doubled consonant left in front of ing or ed
	always_comb begin
		held     = 3'($countones(win_vld));
		keep_pre = held - sel_len;
		if (sel_len == 3'd3) begin
			dbl = (win[2] == win[1]) && doublable(win[2]);
		end else begin
			dbl = (win[3] == win[2]) && doublable(win[3]);
		end
		undo    = found && sel_ud && (keep_pre >= 3'd2) && dbl;
		keep    = keep_pre - {2'b00, undo};
		removed = found ? (sel_len - {2'b00, sel_y} + {2'b00, undo}) : 3'd0;
		nb      = keep + {2'b00, sel_y};
		offset  = 3'(OUT_CELLS) - held;
	end

	// flush beats, left-aligned, with y appended where the rule asks
	always_comb begin
		for (int i = 0; i < OUT_CELLS; i++) begin
			src = 3'(i) + offset;
			beats[i].ch = CHAR_Y;
			if (3'(i) < keep) begin
				beats[i].ch = win[src];
			end
			beat_vld[i]   = 3'(i) < nb;
			beats[i].last = (3'(i) + 3'd1) == nb;
			beats[i].rem  = beats[i].last ? removed : 3'd0;
			beats[i].ovf  = beats[i].last && ovf;
		end
	end

endmodule

/* design/suffix_stripping_stemmer.sv */
// Streaming light stemmer. Characters come in one beat per cycle while char_stall
// is low, with word_end on the last one; A-Z are folded to lower case and every
// other byte passes as is. The last five characters sit in a row of window cells,
// so output of a word trails its input by five characters, each entering the
// output chain when the character that pushes it out is taken. On the word-end
// beat the suffix rules are matched in parallel on the tail and up to six stem
// beats are loaded at once into a six-cell output chain that drains one beat per
// cycle while stem_stall is low; the last beat carries stem_end, removed_count
// and overflow. Mid-word characters are taken every cycle, also while the
// previous word's flush drains, unless the window is full and the output chain
// has no free cell. A word-end beat is held off until the output chain has
// emptied, so the word end of a short word that follows a full six-beat flush
// waits for that flush to drain.
// Words reaching MAX_WORD characters go through unstripped with overflow set.
module suffix_stripping_stemmer #(
	parameter int MAX_WORD = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       word_end,
	output logic       stem_valid,
	input  logic       stem_stall,
	output logic [7:0] out_char,
	output logic       stem_end,
	output logic [2:0] removed_count,
	output logic       overflow
);
	import stm_pkg::*;

	localparam int LEN_W   = $clog2(MAX_WORD + 1);
	localparam int LEN_CAP = 8;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) begin
			return c | 8'h20;
		end
		return c;
	endfunction

	logic [LEN_W-1:0] wl_q;
	logic [LEN_W-1:0] wl_new;
	logic             ovf;
	logic [3:0]       len_cap;
	logic             char_acc;
	logic [7:0]       x_ch;

	logic [WIN_CELLS-1:0][7:0] win_ch;
	logic [WIN_CELLS-1:0]      win_vld;
	logic [OUT_CELLS-1:0][7:0] tail;
	logic [OUT_CELLS-1:0]      tail_vld;
	wctl_t                     wctl;

	beat_t [OUT_CELLS-1:0] fl_beats;
	logic  [OUT_CELLS-1:0] fl_vld;
	beat_t [OUT_CELLS-1:0] ob;
	logic  [OUT_CELLS-1:0] ovld;
	logic  [OUT_CELLS-1:0] osv;
	logic  [OUT_CELLS-1:0] oend;
	beat_t                 push_beat;
	octl_t                 octl;

	assign x_ch     = fold(char_code);
	assign char_acc = char_valid && !char_stall;

	// word length, saturating at MAX_WORD
	assign wl_new  = (wl_q == LEN_W'(MAX_WORD)) ? wl_q : wl_q + 1'b1;
	assign ovf     = wl_new == LEN_W'(MAX_WORD);
	assign len_cap = (wl_new >= LEN_W'(LEN_CAP)) ? 4'(LEN_CAP) : wl_new[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0;
		end else if (char_acc) begin
			wl_q <= word_end ? '0 : wl_new;
		end
	end

	// window cells shift toward cell 0, newest character enters at the top
	assign wctl.shift = char_acc && !word_end;
	assign wctl.clear = char_acc && word_end;

	for (genvar i = 0; i < WIN_CELLS; i++) begin : g_win
		logic [7:0] nxt_ch;
		logic       nxt_vld;
		if (i < WIN_CELLS - 1) begin : g_mid
			assign nxt_ch  = win_ch[i+1];
			assign nxt_vld = win_vld[i+1];
		end else begin : g_top
			assign nxt_ch  = x_ch;
			assign nxt_vld = 1'b1;
		end
		stm_win_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (wctl),
			.nxt_ch  (nxt_ch),
			.nxt_vld (nxt_vld),
			.ch      (win_ch[i]),
			.vld     (win_vld[i])
		);
	end

	// tail view: held cells plus the incoming character
	assign tail     = {x_ch, win_ch};
	assign tail_vld = {1'b1, win_vld};

	stm_match u_match (
		.win      (tail),
		.win_vld  (tail_vld),
		.len_cap  (len_cap),
		.ovf      (ovf),
		.beats    (fl_beats),
		.beat_vld (fl_vld)
	);

	// mid-word beat pushed out of the oldest window cell
	assign push_beat.ch   = win_ch[0];
	assign push_beat.last = 1'b0;
	assign push_beat.rem  = 3'd0;
	assign push_beat.ovf  = 1'b0;

	assign octl.pop  = stem_valid && !stem_stall;
	assign octl.push = char_acc && !word_end && win_vld[0];
	assign octl.load = char_acc && word_end;

	// output chain, cell 0 drives the port
	for (genvar i = 0; i < OUT_CELLS; i++) begin : g_out
		beat_t nxt_beat;
		logic  nxt_vld;
		logic  prv_sv;
		if (i < OUT_CELLS - 1) begin : g_mid
			assign nxt_beat = ob[i+1];
			assign nxt_vld  = ovld[i+1];
		end else begin : g_top
			assign nxt_beat = '0;
			assign nxt_vld  = 1'b0;
		end
		if (i == 0) begin : g_head
			assign prv_sv = 1'b1;
		end else begin : g_rest
			assign prv_sv = osv[i-1];
		end
		stm_out_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (octl),
			.nxt_beat  (nxt_beat),
			.nxt_vld   (nxt_vld),
			.prv_sv    (prv_sv),
			.push_beat (push_beat),
			.ld_beat   (fl_beats[i]),
			.ld_vld    (fl_vld[i]),
			.beat      (ob[i]),
			.vld       (ovld[i]),
			.sv        (osv[i])
		);
		assign oend[i] = ob[i].last;
	end

	// word end needs an empty chain, a mid-word push needs one free cell
	assign char_stall = word_end ? (|osv) : (win_vld[0] && osv[OUT_CELLS-1]);

	assign stem_valid    = ovld[0];
	assign out_char      = ob[0].ch;
	assign stem_end      = ob[0].last;
	assign removed_count = ob[0].rem;
	assign overflow      = ob[0].ovf;

	// output chain stays packed toward the head
	a_out_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld[OUT_CELLS-1:1] & ~ovld[OUT_CELLS-2:0]) == '0)
		else $error("output chain has a gap");

	// window stays packed toward the newest cell
	a_win_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(win_vld[WIN_CELLS-2:0] & ~win_vld[WIN_CELLS-1:1]) == '0)
		else $error("window has a gap");

	// word end empties the window and queues exactly one stem end
	a_word_flush: assert property (@(posedge clk) disable iff (!arst_n)
		char_acc && word_end |=> win_vld == '0 && wl_q == '0 &&
		$countones(ovld & oend) == 1)
		else $error("word end flush malformed");

	// tags only travel with the stem end beat
	a_tag_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stem_valid && !stem_end |-> removed_count == 3'd0 && !overflow)
		else $error("tag on a non-final beat");

	// a mid-word beat never queues a stem end
	a_mid_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		char_acc && !word_end && !(ovld[0] && !octl.pop) |=>
		$countones(ovld & oend) <= 1)
		else $error("extra stem end queued");

endmodule

/* dv/tb_suffix_stripping_stemmer.sv */
`timescale 1ns / 100ps

module tb_suffix_stripping_stemmer;

	import stm_pkg::beat_t;

	localparam int MAX_WORD    = 64;
	localparam int WIN_DEPTH   = 6;
	localparam int NUM_SFX     = 22;
	localparam int RAND_CHARS  = 40;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 20;
	localparam logic [7:0] UPPER_A = 8'h41;
	localparam logic [7:0] UPPER_Z = 8'h5a;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7a;
	localparam logic [7:0] LOWER_Y = 8'h79;

	// one character beat of the stimulus plan
	typedef struct {
		logic [7:0] ch;
		logic       we;
		bit         typed;
		bit         lead;
	} char_item_t;

	// stem written out by hand for a directed word
	typedef struct {
		string stem;
		int    rem;
		bit    ovf;
	} typed_stem_t;

	typedef struct {
		string word;
		string stem;
		int    rem;
		bit    typed;
	} word_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	logic [7:0] char_code = 8'h00;
	logic       word_end = 1'b0;
	logic       stem_valid;
	logic       stem_stall = 1'b0;
	logic [7:0] out_char;
	logic       stem_end;
	logic [2:0] removed_count;
	logic       overflow;

	// suffixes in match order, longest first
	string sfx_tab[NUM_SFX] = '{
		"ation", "ition", "ness", "ment", "able", "ible", "tion", "sion",
		"ies", "ied", "ing", "est", "ous", "ive", "ful", "ize", "ise",
		"ed", "er", "ly", "es", "s"
	};
	string doubles = "nptdgmblr";

	// directed words; stems typed in only where obvious
	word_row_t word_rows[16] = '{
		'{"s", "s", 0, 1},
		'{"cat", "cat", 0, 1},
		'{"cats", "cat", 1, 1},
		'{"running", "run", 4, 1},
		'{"stopped", "stop", 3, 1},
		'{"WALKED", "walk", 2, 1},
		'{"ponies", "pony", 2, 1},
		'{"creation", "cre", 5, 1},
		'{"happiness", "happi", 4, 1},
		'{"@AZ[az{", "@az[az{", 0, 1},
		'{"nation", "", 0, 0},
		'{"cried", "", 0, 0},
		'{"need", "", 0, 0},
		'{"buzzing", "", 0, 0},
		'{"Studies", "", 0, 0},
		'{"hopefulness", "", 0, 0}
	};

	// byte zero and high bytes as plain characters
	logic [7:0] odd_bytes[12] = '{
		8'h00, 8'hff, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h69, 8'h6e, 8'h67,
		8'h80, 8'h7f
	};

	char_item_t  char_plan[$];
	typed_stem_t typed_stems[$];
	beat_t       stems_due[$];
	beat_t       stem_fresh[$];

	// stemmer state mirror
	logic [7:0] win[WIN_DEPTH];
	int         held;
	int         word_len;

	char_item_t on_wire;
	int         plan_pos;
	int         directed_len;
	int         chars_in;
	int         words_in;
	int         beats_out;
	int         stripped_words;
	int         ovf_words;
	int         errors;
	int         cycle_no;
	int         quiet;
	bit         run;
	wire        calm = (cycle_no >= 60 && cycle_no < 160);

	suffix_stripping_stemmer #(
		.MAX_WORD(MAX_WORD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.word_end(word_end),
		.stem_valid(stem_valid),
		.stem_stall(stem_stall),
		.out_char(out_char),
		.stem_end(stem_end),
		.removed_count(removed_count),
		.overflow(overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit doublable(logic [7:0] c);
		return c inside {"n", "p", "t", "d", "g", "m", "b", "l", "r"};
	endfunction

	function automatic void emit(logic [7:0] c, logic last, int rem, logic ovf);
		beat_t b;
		b.ch = c;
		b.last = last;
		b.rem = rem[2:0];
		b.ovf = ovf;
		stem_fresh.push_back(b);
	endfunction

	// fold, shift through the tail window, strip at word end
	task automatic strip_suffix_char(input logic [7:0] raw, input logic last);
		logic [7:0] c;
		int         keep;
		int         removed;
		int         sl;
		bit         ovf;
		bit         add_y;
		bit         hit;
		bit         fin;
		c = (raw >= UPPER_A && raw <= UPPER_Z) ? raw + 8'd32 : raw;
		if (held >= WIN_DEPTH)
			held = WIN_DEPTH - 1;
		win[held] = c;
		held++;
		if (word_len < MAX_WORD)
			word_len++;
		if (!last) begin
			if (held == WIN_DEPTH) begin
				emit(win[0], 1'b0, 0, 1'b0);
				for (int k = 0; k < WIN_DEPTH - 1; k++)
					win[k] = win[k + 1];
				win[WIN_DEPTH - 1] = 8'h00;
				held = WIN_DEPTH - 1;
			end
		end else begin
			ovf = word_len >= MAX_WORD;
			keep = held;
			removed = 0;
			add_y = 1'b0;
			if (!ovf && word_len >= 4) begin
				for (int r = 0; r < NUM_SFX; r++) begin
					sl = sfx_tab[r].len();
					hit = (word_len >= sl + 3) && (sl <= held);
					for (int k = 0; k < sl && hit; k++)
						hit = win[held - sl + k] == sfx_tab[r][k];
					if (hit) begin
						keep = held - sl;
						removed = sl;
						if (sfx_tab[r] == "ies" || sfx_tab[r] == "ied") begin
							add_y = 1'b1;
							removed--;
						end else if ((sfx_tab[r] == "ing" || sfx_tab[r] == "ed") && keep >= 2
								&& win[keep - 1] == win[keep - 2] && doublable(win[keep - 1])) begin
							keep--;
							removed++;
						end
						break;
					end
				end
			end
			for (int i = 0; i < keep; i++) begin
				fin = (i + 1 == keep) && !add_y;
				emit(win[i], fin, fin ? removed : 0, fin ? ovf : 1'b0);
			end
			if (add_y)
				emit(LOWER_Y, 1'b1, removed, ovf);
			for (int k = 0; k < WIN_DEPTH; k++)
				win[k] = 8'h00;
			held = 0;
			word_len = 0;
		end
	endtask

	function automatic void plan_char(logic [7:0] c, logic we, bit typed, bit lead);
		char_item_t it;
		it.ch = c;
		it.we = we;
		it.typed = typed;
		it.lead = lead;
		char_plan.push_back(it);
	endfunction

	function automatic void plan_string(string w, bit typed);
		for (int k = 0; k < w.len(); k++)
			plan_char(w[k], k == w.len() - 1, typed, typed && k == 0);
	endfunction

	// random word: mostly letters plus a suffix, some noise, some overlong
	task automatic plan_random_word();
		logic [7:0] letters[$];
		int         kind;
		int         base;
		string      sfx;
		logic [7:0] d;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			base = $urandom_range(1, 8);
			repeat (base)
				letters.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (kind < 20)
				base = $urandom_range(1, 3);
			else if (kind < 97)
				base = $urandom_range(1, 6);
			else
				base = $urandom_range(MAX_WORD - 6, MAX_WORD + 4);
			repeat (base)
				letters.push_back(8'($urandom_range(LOWER_A, LOWER_Z)));
			if (kind >= 20 && $urandom_range(0, 3) == 0) begin
				d = doubles[$urandom_range(0, doubles.len() - 1)];
				letters.push_back(d);
				letters.push_back(d);
			end
			if (kind >= 20 && $urandom_range(0, 4) != 0) begin
				sfx = sfx_tab[$urandom_range(0, NUM_SFX - 1)];
				for (int k = 0; k < sfx.len(); k++)
					letters.push_back(sfx[k]);
			end
			// some upper case to exercise folding
			foreach (letters[k])
				if ($urandom_range(0, 6) == 0)
					letters[k] = letters[k] - 8'd32;
		end
		foreach (letters[k])
			plan_char(letters[k], k == letters.size() - 1, 1'b0, 1'b0);
	endtask

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// character side: hold payload while stalled, idle at random
	always @(posedge clk) begin : drive
		typed_stem_t ts;
		beat_t       b;
		bit          idle;
		idle = calm ? 1'b0 : ($urandom_range(0, 99) < 6);
		if (char_valid && !char_stall) begin
			chars_in++;
			if (on_wire.we)
				words_in++;
			if (on_wire.lead) begin
				ts = typed_stems.pop_front();
				for (int k = 0; k < ts.stem.len(); k++) begin
					b.ch = ts.stem[k];
					b.last = k == ts.stem.len() - 1;
					b.rem = b.last ? ts.rem[2:0] : 3'd0;
					b.ovf = b.last ? ts.ovf : 1'b0;
					stems_due.push_back(b);
				end
			end
			strip_suffix_char(on_wire.ch, on_wire.we);
			if (!on_wire.typed)
				foreach (stem_fresh[k])
					stems_due.push_back(stem_fresh[k]);
			stem_fresh.delete();
		end
		if (!char_valid || !char_stall) begin
			if (run && plan_pos < char_plan.size() && !idle) begin
				on_wire = char_plan[plan_pos];
				plan_pos++;
				char_valid <= 1'b1;
				char_code <= on_wire.ch;
				word_end <= on_wire.we;
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// stem side: compare each beat with the oldest expected one
	always @(posedge clk) begin : observe
		beat_t want;
		if (arst_n && stem_valid && !stem_stall) begin
			beats_out++;
			if (stem_end && overflow)
				ovf_words++;
			if (stem_end && removed_count != 3'd0)
				stripped_words++;
			if (stems_due.size() == 0) begin
				$display("%0t: unexpected stem beat, actual char %0h end %0b", $time,
					out_char, stem_end);
				errors++;
			end else begin
				want = stems_due.pop_front();
				check_field("out_char", want.ch, out_char);
				check_field("stem_end", 8'(want.last), 8'(stem_end));
				check_field("removed_count", 8'(want.rem), 8'(removed_count));
				check_field("overflow", 8'(want.ovf), 8'(overflow));
			end
		end
		stem_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 6);
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (run) begin
			if ((char_valid && !char_stall) || (stem_valid && !stem_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d stem beats still due", $time,
					quiet, stems_due.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		string w;
		// directed words
		foreach (word_rows[r]) begin
			plan_string(word_rows[r].word, word_rows[r].typed);
			if (word_rows[r].typed)
				typed_stems.push_back('{word_rows[r].stem, word_rows[r].rem, 1'b0});
		end
		foreach (odd_bytes[k])
			plan_char(odd_bytes[k], k == 3 || k == 9 || k == 11, 1'b0, 1'b0);
		// overlong word passes through unchanged
		w = "";
		repeat (MAX_WORD - 3)
			w = {w, "b"};
		w = {w, "ing"};
		plan_string(w, 1'b1);
		typed_stems.push_back('{w, 0, 1'b1});
		directed_len = char_plan.size();

		while (char_plan.size() - directed_len < RAND_CHARS)
			plan_random_word();

		held = 0;
		word_len = 0;
		foreach (win[k])
			win[k] = 8'h00;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run <= 1'b1;

		while (chars_in < char_plan.size() || stems_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (stems_due.size() != 0) begin
			$display("%0t: %0d stem beats never arrived", $time, stems_due.size());
			errors++;
		end

		$display("%0d characters in %0d words, %0d directed; %0d stem beats out", chars_in,
			words_in, directed_len, beats_out);
		$display("%0d stems had a suffix removed, %0d words overflowed, %0d errors",
			stripped_words, ovf_words, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
